>>> hw/rtl/vqsr_pkg.sv
package vqsr_pkg;

    localparam int QueueDepthDefault = 256;
    localparam int MaxChainDefault   = 64;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 9;

    localparam logic [CfgIdxW-1:0] CfgQueueSize   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgStarted     = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgEventIdx    = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgChainLimit  = 2'd3;

    typedef enum logic [2:0] {
        REQ_WR_DESC   = 3'd0,
        REQ_WR_AVAIL  = 3'd1,
        REQ_WR_AIDX   = 3'd2,
        REQ_GET_CHAIN = 3'd3,
        REQ_RELEASE   = 3'd4,
        REQ_RETURN    = 3'd5,
        REQ_END       = 3'd6,
        REQ_UNUSED    = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RING  = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_DESC,
        S_EMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  slot;
        logic [63:0] desc_addr;
        logic [31:0] desc_len;
        logic [15:0] desc_next;
        logic        desc_has_next;
        logic [15:0] head_id;
        logic [15:0] avail_index;
        logic        no_interrupt;
        logic [15:0] used_event_index;
        logic [15:0] chain_count;
        logic [31:0] io_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] chain_head;
        logic [63:0] buf_addr;
        logic [31:0] buf_len;
        logic [6:0]  desc_position;
        logic        last;
        logic        has_data;
        logic        raise_interrupt;
        logic [7:0]  used_slot;
        logic [15:0] used_index;
    } t_out_item;

endpackage

>>> hw/rtl/vqsr_in_if.sv
interface vqsr_in_if
    import vqsr_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/vqsr_out_if.sv
interface vqsr_out_if
    import vqsr_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/vqsr_store.sv
// Descriptor and available ring memories with registered reads.
module vqsr_store
    import vqsr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    localparam int AW = $clog2(QUEUE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_desc_we,
    input  logic [AW-1:0] i_desc_waddr,
    input  logic [112:0]  i_desc_wdata,
    input  logic [AW-1:0] i_desc_raddr,
    output logic [112:0]  o_desc_rdata,
    input  logic          i_avail_we,
    input  logic [AW-1:0] i_avail_waddr,
    input  logic [15:0]   i_avail_wdata,
    input  logic [AW-1:0] i_avail_raddr,
    output logic [15:0]   o_avail_rdata
);
    logic [112:0] r_desc_mem  [QUEUE_DEPTH];
    logic [15:0]  r_avail_mem [QUEUE_DEPTH];

    // Descriptor memory: address, length and link packed in one word.
    always_ff @(posedge i_clk) begin
        if (i_desc_we) begin
            r_desc_mem[i_desc_waddr] <= i_desc_wdata;
        end
        o_desc_rdata <= r_desc_mem[i_desc_raddr];
    end

    // Available ring memory.
    always_ff @(posedge i_clk) begin
        if (i_avail_we) begin
            r_avail_mem[i_avail_waddr] <= i_avail_wdata;
        end
        o_avail_rdata <= r_avail_mem[i_avail_raddr];
    end
endmodule

>>> hw/rtl/virtqueue_split_ring_device.sv
// Device side of a split virtqueue. Writes of descriptors, available entries,
// the available index and the return, release and end requests are handled in
// S_HEAD and their result is registered and held in S_OUT; a new request is
// taken only once that result has been taken. A get-chain request reads the
// head from the available ring memory and then each descriptor in turn from
// the descriptor memory through S_DESC and S_EMIT, reading the next one only
// after the previous result has been taken; each result waits in the output
// register until it is taken. Descriptors must be written before they are
// read.
module virtqueue_split_ring_device
    import vqsr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    parameter int MAX_CHAIN   = MaxChainDefault,
    localparam int AW = $clog2(QUEUE_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    vqsr_in_if.sink             i_in,
    vqsr_out_if.source          o_out
);
    logic [8:0]  r_qsize;
    logic        r_started;
    logic        r_evidx;
    logic [6:0]  r_climit;

    logic [15:0] r_gaidx, r_gevent, r_navail, r_nused, r_sused;
    logic        r_gnoint;

    t_state      r_state, n_state;
    t_in_item    r_item;
    logic [15:0] r_head, r_cur;
    logic [6:0]  r_cnt, r_limit;
    t_out_item   r_out, n_out;
    logic        r_ovalid, n_ovalid;

    logic [112:0] w_desc_rdata;
    logic [15:0]  w_avail_rdata;
    logic [15:0]  w_mask;
    logic [15:0]  w_ndesc;
    logic [15:0]  w_ea, w_eb;
    logic         w_hasdata;
    logic         w_accept;
    logic         w_take;
    logic         w_cur_bad;

    assign w_mask    = 16'(r_qsize - 9'd1);
    assign w_ndesc   = r_gaidx - r_navail;
    assign w_accept  = i_in.valid && i_in.ready;
    assign w_take    = r_ovalid && o_out.ready;
    assign w_hasdata = r_started && (r_gaidx != r_navail);
    assign w_ea      = r_nused - r_gevent - 16'd1;
    assign w_eb      = r_nused - r_sused;
    assign w_cur_bad = ({16'd0, r_cur} >= {23'd0, r_qsize});

    vqsr_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
        .i_clk         (i_clk),
        .i_desc_we     (w_accept && i_in.data.req_type == REQ_WR_DESC),
        .i_desc_waddr  (AW'(i_in.data.slot)),
        .i_desc_wdata  ({i_in.data.desc_has_next, i_in.data.desc_next,
                         i_in.data.desc_len, i_in.data.desc_addr}),
        .i_desc_raddr  (AW'(r_cur)),
        .o_desc_rdata  (w_desc_rdata),
        .i_avail_we    (w_accept && i_in.data.req_type == REQ_WR_AVAIL),
        .i_avail_waddr (AW'(i_in.data.slot)),
        .i_avail_wdata (i_in.data.head_id),
        .i_avail_raddr (AW'(r_navail & w_mask)),
        .o_avail_rdata (w_avail_rdata)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qsize   <= 9'd256;
            r_started <= 1'b0;
            r_evidx   <= 1'b0;
            r_climit  <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgQueueSize:  r_qsize   <= i_cfg_data;
                CfgStarted:    r_started <= i_cfg_data[0];
                CfgEventIdx:   r_evidx   <= i_cfg_data[0];
                CfgChainLimit: r_climit  <= i_cfg_data[6:0];
                default:       r_qsize   <= r_qsize;
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_HEAD;
            S_HEAD: begin
                if (r_item.req_type == REQ_GET_CHAIN && w_ndesc != 16'd0
                    && {1'b0, w_ndesc} <= {8'd0, r_qsize}) begin
                    n_state = S_DESC;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DESC: begin
                if (!r_ovalid) n_state = S_EMIT;
            end
            S_EMIT: n_state = S_OUT;
            S_OUT: begin
                if (!r_ovalid) n_state = S_IDLE;
                else if (w_take && !r_out.last) n_state = S_DESC;
                else if (w_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Next result and its valid flag.
    always_comb begin
        n_out    = r_out;
        n_ovalid = r_ovalid && !w_take;
        case (r_state)
            S_HEAD: begin
                n_out            = '0;
                n_ovalid         = 1'b1;
                n_out.last       = 1'b1;
                n_out.has_data   = w_hasdata;
                n_out.used_index = (r_item.req_type == REQ_RELEASE) ?
                                   r_nused + 16'd1 : r_nused;
                case (r_item.req_type)
                    REQ_WR_AIDX: begin
                        n_out.has_data = r_started && (r_item.avail_index != r_navail);
                    end
                    REQ_GET_CHAIN: begin
                        if (w_ndesc == 16'd0) begin
                            n_out.status = ST_EMPTY;
                        end else if ({1'b0, w_ndesc} > {8'd0, r_qsize}) begin
                            n_out.status = ST_RING;
                        end else begin
                            n_ovalid = 1'b0;
                        end
                    end
                    REQ_RELEASE: begin
                        n_out.chain_head = r_item.head_id;
                        n_out.buf_len    = r_item.io_length;
                        n_out.used_slot  = 8'(r_nused & w_mask);
                    end
                    REQ_RETURN: begin
                        n_out.has_data = r_started &&
                            (r_gaidx != 16'(r_navail - r_item.chain_count));
                    end
                    REQ_END: begin
                        n_out.raise_interrupt = r_evidx ? (w_ea < w_eb) :
                            ((r_nused != r_sused) && !r_gnoint);
                    end
                    default: ;
                endcase
            end
            S_EMIT: begin
                n_out            = '0;
                n_ovalid         = 1'b1;
                n_out.chain_head = r_head;
                n_out.has_data   = w_hasdata;
                n_out.used_index = r_nused;
                if (w_cur_bad) begin
                    n_out.status        = ST_BAD;
                    n_out.desc_position = r_cnt;
                    n_out.last          = 1'b1;
                end else begin
                    n_out.buf_addr      = w_desc_rdata[63:0];
                    n_out.buf_len       = w_desc_rdata[95:64];
                    n_out.desc_position = r_cnt + 7'd1;
                    n_out.last          = !w_desc_rdata[112] ||
                                          (r_cnt + 7'd1 >= r_limit);
                end
            end
            default: ;
        endcase
    end

    // Datapath and queue state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_gaidx  <= '0;
            r_gnoint <= 1'b0;
            r_gevent <= '0;
            r_navail <= '0;
            r_nused  <= '0;
            r_sused  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_out    <= n_out;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) r_item <= i_in.data;
                end
                S_HEAD: begin
                    r_cnt    <= '0;
                    r_limit  <= (r_climit == 7'd0) ? 7'd1 :
                                (r_climit > 7'(MAX_CHAIN)) ? 7'(MAX_CHAIN) : r_climit;
                    case (r_item.req_type)
                        REQ_WR_AIDX: begin
                            r_gaidx  <= r_item.avail_index;
                            r_gnoint <= r_item.no_interrupt;
                            r_gevent <= r_item.used_event_index;
                        end
                        REQ_GET_CHAIN: begin
                            if (w_ndesc != 16'd0 && {1'b0, w_ndesc} <= {8'd0, r_qsize}) begin
                                r_head   <= w_avail_rdata;
                                r_cur    <= w_avail_rdata;
                                r_navail <= r_navail + 16'd1;
                            end
                        end
                        REQ_RELEASE: begin
                            r_nused <= r_nused + 16'd1;
                        end
                        REQ_RETURN: begin
                            r_navail <= r_navail - r_item.chain_count;
                        end
                        REQ_END: begin
                            r_sused <= r_nused;
                        end
                        default: ;
                    endcase
                end
                S_DESC: begin
                    // Memory read of r_cur is issued here, data next cycle.
                end
                S_EMIT: begin
                    if (!w_cur_bad) begin
                        r_cnt <= r_cnt + 7'd1;
                        r_cur <= w_desc_rdata[111:96];
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

>>> hw/rtl/vqsr_checker.sv
// Port-level checks for the virtqueue device.
module vqsr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic o_out_valid,
    input logic o_out_ready,
    input logic o_out_last
);
    // No new transfer in while a result waits.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !i_in_ready) else $error("input ready while result pending");

    // A result stays until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_ready |=> o_out_valid) else $error("result dropped");

    // An accepted item leaves the input side busy next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready) else $error("ready right after transfer");

    // A last result ends the item; non-last keeps input closed.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_ready && !o_out_last |=> !i_in_ready)
        else $error("input opened mid chain");
endmodule

bind virtqueue_split_ring_device vqsr_checker u_vqsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .o_out_valid (o_out.valid),
    .o_out_ready (o_out.ready),
    .o_out_last  (o_out.data.last)
);
